@@ hw/rtl/lir_pkg.sv @@
`default_nettype none

package lir_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int RATE_W      = 16;
    localparam int CNT_W       = 16;
    localparam int POS_W       = 32;
    localparam int CFG_INDEX_W = 8;

    localparam int OUT_LIMIT   = 32768;
    localparam int MAX_BLOCK   = 32768;
    localparam int HOLD_DEPTH  = 4;
    localparam int MAX_RESULTS = 12;
    localparam int DATA_STEPS  = 16;
    localparam int FRAC_STEPS  = 4;

    localparam int HOLD_CNT_W  = $clog2(HOLD_DEPTH + 1);
    localparam int HOLD_IDX_W  = $clog2(HOLD_DEPTH);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int STEP_W      = $clog2(DATA_STEPS + 1);

    localparam logic [RATE_W-1:0] RATE_LOW  = RATE_W'(8000);
    localparam logic [RATE_W-1:0] RATE_HIGH = RATE_W'(48000);

    localparam logic [CFG_INDEX_W-1:0] REG_SRC_RATE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DST_RATE = CFG_INDEX_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV_DATA,
        S_DIV_FRAC,
        S_DRAIN,
        S_FINAL
    } state_t;

    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] v);
        logic [RATE_W-1:0] r;
        r = v;
        if (v < RATE_LOW)
        begin
            r = RATE_LOW;
        end
        else if (v > RATE_HIGH)
        begin
            r = RATE_HIGH;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lir_in_if.sv @@
`default_nettype none

interface lir_in_if;
    import lir_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       in_last;

    modport source (output valid, in_sample, in_last, input ready);
    modport sink   (input valid, in_sample, in_last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lir_out_if.sv @@
`default_nettype none

interface lir_out_if;
    import lir_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       out_last;

    modport source (output valid, out_sample, out_last, input ready);
    modport sink   (input valid, out_sample, out_last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lir_cfg_if.sv @@
`default_nettype none

interface lir_cfg_if;
    import lir_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [RATE_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/linear_interp_resampler.sv @@
// channel     dir   handshake        word
// pcm         in    valid / ready    in_sample[15:0] signed, in_last
// resampled   out   valid / ready    out_sample[15:0] signed, out_last
// cfg         in    valid / ready    index[7:0], data[15:0] (0 src_rate, 1 dst_rate)
//
// for each output it computes, an input word runs a 16-step serial quotient,
// then a 4-step position update in the same divider, and then it releases
// the output words that are due
// reset: rates 8000 hz, block state cleared at once, no clearing pass
// one output register: the sequencer waits only when it is full and not taken
// pcm and cfg are taken only while the sequencer is idle, cfg first
`default_nettype none

module linear_interp_resampler (
    input  logic      clk,
    input  logic      rst_n,
    lir_in_if.sink    pcm,
    lir_out_if.source resampled,
    lir_cfg_if.sink   cfg
);
    import lir_pkg::*;

    state_t state_reg, state_next;

    logic [RATE_W-1:0]          src_rate_reg, src_rate_next;
    logic [RATE_W-1:0]          dst_rate_reg, dst_rate_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic signed [SAMPLE_W-1:0] smp_reg, smp_next;
    logic                       last_reg, last_next;
    logic                       take_reg, take_next;
    logic                       pair_reg, pair_next;
    logic                       phase_reg, phase_next;
    logic                       drain_exit_reg, drain_exit_next;
    logic [CNT_W-1:0]           icnt_reg, icnt_next;
    logic [CNT_W-1:0]           ocnt_reg, ocnt_next;
    logic [CNT_W-1:0]           nsi_reg, nsi_next;
    logic [RATE_W-1:0]          frac_reg, frac_next;
    logic                       cap_reg, cap_next;
    logic [POS_W-1:0]           out_pos1_reg, out_pos1_next;
    logic [POS_W-1:0]           out_pos2_reg, out_pos2_next;
    logic [POS_W-1:0]           in_pos_reg, in_pos_next;
    logic signed [SAMPLE_W-1:0] held_reg [HOLD_DEPTH];
    logic signed [SAMPLE_W-1:0] held_next [HOLD_DEPTH];
    logic [HOLD_CNT_W-1:0]      held_cnt_reg, held_cnt_next;
    logic [RATE_W-1:0]          rem_reg, rem_next;
    logic [RATE_W-1:0]          shf_reg, shf_next;
    logic [SAMPLE_W-1:0]        quo_reg, quo_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       neg_reg, neg_next;
    logic [RES_CNT_W-1:0]       res_cnt_reg, res_cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                       out_last_reg, out_last_next;

    logic                       in_ready_c;
    logic                       cfg_ready_c;
    logic                       loop_go;
    logic                       ex1;
    logic                       ex2;
    logic                       at_cap;
    logic                       can_emit;
    logic                       emit_en;
    logic                       emit_lst;
    logic                       clear_blk;
    logic [RATE_W-1:0]          cfg_val;
    logic signed [SAMPLE_W:0]   a_ext;
    logic signed [SAMPLE_W:0]   b_ext;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SAMPLE_W:0]   mag_ext;
    logic [SAMPLE_W-1:0]        mag;
    logic [2*SAMPLE_W-1:0]      prod;
    logic [RATE_W:0]            trial;
    logic                       ge;
    logic [RATE_W-1:0]          rem_step;
    logic [SAMPLE_W-1:0]        quo_step;
    logic signed [SAMPLE_W:0]   q_mag;
    logic signed [SAMPLE_W:0]   q_signed;
    logic signed [SAMPLE_W:0]   val_ext;
    logic [RATE_W:0]            f2;
    logic                       cond0;
    logic                       cond1;

    assign pcm.ready            = in_ready_c;
    assign cfg.ready            = cfg_ready_c;
    assign resampled.valid      = out_valid_reg;
    assign resampled.out_sample = out_sample_reg;
    assign resampled.out_last   = out_last_reg;

    // datapath around the shared divider
    assign a_ext    = (SAMPLE_W + 1)'(prev_reg);
    assign b_ext    = phase_reg ? '0 : (SAMPLE_W + 1)'(smp_reg);
    assign diff     = b_ext - a_ext;
    assign mag_ext  = diff[SAMPLE_W] ? -diff : diff;
    assign mag      = mag_ext[SAMPLE_W-1:0];
    assign prod     = (2 * SAMPLE_W)'(mag) * (2 * SAMPLE_W)'(frac_reg);
    assign trial    = {rem_reg, shf_reg[RATE_W-1]};
    assign ge       = trial >= {1'b0, dst_rate_reg};
    assign rem_step = ge ? RATE_W'(trial - {1'b0, dst_rate_reg}) : trial[RATE_W-1:0];
    assign quo_step = {quo_reg[SAMPLE_W-2:0], ge};
    assign q_mag    = {1'b0, quo_step};
    assign q_signed = neg_reg ? -q_mag : q_mag;
    assign val_ext  = a_ext + q_signed;
    assign f2       = {1'b0, frac_reg} + {1'b0, src_rate_reg};

    // block bookkeeping
    assign cond0    = pair_reg && (({1'b0, nsi_reg} + (CNT_W + 1)'(2)) == {1'b0, icnt_reg});
    assign cond1    = ({1'b0, nsi_reg} + (CNT_W + 1)'(1)) == {1'b0, icnt_reg};
    assign loop_go  = !cap_reg && (held_cnt_reg < HOLD_CNT_W'(HOLD_DEPTH))
                      && (phase_reg ? cond1 : cond0);
    assign ex1      = out_pos1_reg <= in_pos_reg;
    assign ex2      = out_pos2_reg <= in_pos_reg;
    assign at_cap   = ocnt_reg == CNT_W'(OUT_LIMIT - 1);
    assign can_emit = (res_cnt_reg >= RES_CNT_W'(MAX_RESULTS)) || !out_valid_reg
                      || resampled.ready;
    assign cfg_val  = clamp_rate(cfg.data);

    always_comb
    begin
        state_next      = state_reg;
        src_rate_next   = src_rate_reg;
        dst_rate_next   = dst_rate_reg;
        prev_next       = prev_reg;
        smp_next        = smp_reg;
        last_next       = last_reg;
        take_next       = take_reg;
        pair_next       = pair_reg;
        phase_next      = phase_reg;
        drain_exit_next = drain_exit_reg;
        icnt_next       = icnt_reg;
        ocnt_next       = ocnt_reg;
        nsi_next        = nsi_reg;
        frac_next       = frac_reg;
        cap_next        = cap_reg;
        out_pos1_next   = out_pos1_reg;
        out_pos2_next   = out_pos2_reg;
        in_pos_next     = in_pos_reg;
        held_next       = held_reg;
        held_cnt_next   = held_cnt_reg;
        rem_next        = rem_reg;
        shf_next        = shf_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        neg_next        = neg_reg;
        res_cnt_next    = res_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        in_ready_c      = 1'b0;
        cfg_ready_c     = 1'b0;
        emit_en         = 1'b0;
        emit_lst        = 1'b0;
        clear_blk       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cfg_ready_c = 1'b1;
                in_ready_c  = !cfg.valid;
                if (cfg.valid)
                begin
                    if (cfg.index == REG_SRC_RATE)
                    begin
                        src_rate_next = cfg_val;
                        clear_blk     = 1'b1;
                    end
                    else if (cfg.index == REG_DST_RATE)
                    begin
                        dst_rate_next = cfg_val;
                        clear_blk     = 1'b1;
                    end
                end
                else if (pcm.valid)
                begin
                    smp_next     = pcm.in_sample;
                    last_next    = pcm.in_last;
                    phase_next   = 1'b0;
                    res_cnt_next = '0;
                    state_next   = S_CHECK;
                    if (icnt_reg < CNT_W'(MAX_BLOCK))
                    begin
                        take_next   = 1'b1;
                        pair_next   = icnt_reg != '0;
                        icnt_next   = icnt_reg + CNT_W'(1);
                        in_pos_next = in_pos_reg + POS_W'(dst_rate_reg);
                    end
                    else
                    begin
                        take_next = 1'b0;
                        pair_next = 1'b0;
                    end
                end
            end

            S_CHECK:
            begin
                if (loop_go)
                begin
                    state_next = S_MUL;
                end
                else if (!phase_reg)
                begin
                    if (take_reg)
                    begin
                        prev_next = smp_reg;
                    end
                    pair_next = 1'b0;
                    if (last_reg)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        drain_exit_next = 1'b1;
                        state_next      = S_DRAIN;
                    end
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end

            S_MUL:
            begin
                rem_next   = prod[2*SAMPLE_W-1:SAMPLE_W];
                shf_next   = prod[SAMPLE_W-1:0];
                quo_next   = '0;
                step_next  = STEP_W'(DATA_STEPS);
                neg_next   = diff[SAMPLE_W];
                state_next = S_DIV_DATA;
            end

            S_DIV_DATA:
            begin
                rem_next  = rem_step;
                shf_next  = shf_reg << 1;
                quo_next  = quo_step;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    held_next[held_cnt_reg[HOLD_IDX_W-1:0]] = val_ext[SAMPLE_W-1:0];
                    held_cnt_next = held_cnt_reg + HOLD_CNT_W'(1);
                    // position update: quotient below 16, so four steps
                    rem_next   = RATE_W'(f2[RATE_W:FRAC_STEPS]);
                    shf_next   = {f2[FRAC_STEPS-1:0], (RATE_W - FRAC_STEPS)'(0)};
                    quo_next   = '0;
                    step_next  = STEP_W'(FRAC_STEPS);
                    state_next = S_DIV_FRAC;
                end
            end

            S_DIV_FRAC:
            begin
                rem_next  = rem_step;
                shf_next  = shf_reg << 1;
                quo_next  = quo_step;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    nsi_next        = nsi_reg + CNT_W'(quo_step[FRAC_STEPS-1:0]);
                    frac_next       = rem_step;
                    drain_exit_next = 1'b0;
                    state_next      = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                if (held_cnt_reg == '0 || cap_reg || (at_cap && !ex1)
                    || (!at_cap && !ex2))
                begin
                    state_next = drain_exit_reg ? S_IDLE : S_CHECK;
                end
                else if (can_emit)
                begin
                    emit_en   = 1'b1;
                    ocnt_next = ocnt_reg + CNT_W'(1);
                    if (at_cap)
                    begin
                        emit_lst      = 1'b1;
                        cap_next      = 1'b1;
                        held_cnt_next = '0;
                    end
                    else
                    begin
                        for (int i = 0; i < HOLD_DEPTH - 1; i++)
                        begin
                            held_next[i] = held_reg[i + 1];
                        end
                        held_cnt_next = held_cnt_reg - HOLD_CNT_W'(1);
                        out_pos1_next = out_pos2_reg;
                        out_pos2_next = out_pos2_reg + POS_W'(src_rate_reg);
                    end
                end
            end

            S_FINAL:
            begin
                if (held_cnt_reg == '0 || cap_reg || !ex1)
                begin
                    clear_blk  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (can_emit)
                begin
                    emit_en  = 1'b1;
                    emit_lst = at_cap || !ex2;
                    for (int i = 0; i < HOLD_DEPTH - 1; i++)
                    begin
                        held_next[i] = held_reg[i + 1];
                    end
                    held_cnt_next = held_cnt_reg - HOLD_CNT_W'(1);
                    ocnt_next     = ocnt_reg + CNT_W'(1);
                    out_pos1_next = out_pos2_reg;
                    out_pos2_next = out_pos2_reg + POS_W'(src_rate_reg);
                    if (at_cap || !ex2)
                    begin
                        clear_blk  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output register
        if (resampled.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_en && (res_cnt_reg < RES_CNT_W'(MAX_RESULTS)))
        begin
            out_valid_next  = 1'b1;
            out_sample_next = held_reg[0];
            out_last_next   = emit_lst;
            res_cnt_next    = res_cnt_reg + RES_CNT_W'(1);
        end

        if (clear_blk)
        begin
            prev_next     = '0;
            icnt_next     = '0;
            ocnt_next     = '0;
            nsi_next      = '0;
            frac_next     = '0;
            cap_next      = 1'b0;
            held_cnt_next = '0;
            in_pos_next   = '0;
            out_pos1_next = POS_W'(src_rate_next);
            out_pos2_next = POS_W'(src_rate_next) << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            src_rate_reg   <= RATE_LOW;
            dst_rate_reg   <= RATE_LOW;
            prev_reg       <= '0;
            last_reg       <= 1'b0;
            take_reg       <= 1'b0;
            pair_reg       <= 1'b0;
            phase_reg      <= 1'b0;
            drain_exit_reg <= 1'b0;
            icnt_reg       <= '0;
            ocnt_reg       <= '0;
            nsi_reg        <= '0;
            frac_reg       <= '0;
            cap_reg        <= 1'b0;
            out_pos1_reg   <= POS_W'(RATE_LOW);
            out_pos2_reg   <= POS_W'(RATE_LOW) << 1;
            in_pos_reg     <= '0;
            held_cnt_reg   <= '0;
            step_reg       <= '0;
            res_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            src_rate_reg   <= src_rate_next;
            dst_rate_reg   <= dst_rate_next;
            prev_reg       <= prev_next;
            last_reg       <= last_next;
            take_reg       <= take_next;
            pair_reg       <= pair_next;
            phase_reg      <= phase_next;
            drain_exit_reg <= drain_exit_next;
            icnt_reg       <= icnt_next;
            ocnt_reg       <= ocnt_next;
            nsi_reg        <= nsi_next;
            frac_reg       <= frac_next;
            cap_reg        <= cap_next;
            out_pos1_reg   <= out_pos1_next;
            out_pos2_reg   <= out_pos2_next;
            in_pos_reg     <= in_pos_next;
            held_cnt_reg   <= held_cnt_next;
            step_reg       <= step_next;
            res_cnt_reg    <= res_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg        <= smp_next;
        held_reg       <= held_next;
        rem_reg        <= rem_next;
        shf_reg        <= shf_next;
        quo_reg        <= quo_next;
        neg_reg        <= neg_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/lir_checker.sv @@
`default_nettype none

module lir_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [lir_pkg::SAMPLE_W-1:0] out_sample,
    input logic                               out_last,
    input logic                               cfg_valid,
    input logic                               cfg_ready
);
    import lir_pkg::*;

    // a stalled output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_sample) && $stable(out_last))
        else $error("output word changed while stalled");

    // one input word at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an accept");

    // rate writes and samples never land together
    a_cfg_vs_input: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready && in_valid && in_ready))
        else $error("rate write and sample accepted at the same edge");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pcm.valid),
    .in_ready   (pcm.ready),
    .out_valid  (resampled.valid),
    .out_ready  (resampled.ready),
    .out_sample (resampled.out_sample),
    .out_last   (resampled.out_last),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready)
);

`default_nettype wire

@@ test/tb_linear_interp_resampler.sv @@
`timescale 1ns / 1ps

module tb_linear_interp_resampler;
    import lir_pkg::*;

    localparam int LIMIT        = 2_000_000;
    localparam int SETTLE       = 200;
    localparam int BURST        = 300;
    localparam int RANDOM_WORDS = 480;
    localparam int REPORT_MAX   = 100;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_TOP   = '1;

    typedef enum logic {
        ROW_PCM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } pcm_word_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [SAMPLE_W-1:0]    value;
        logic                   last;
        logic                   fixed;
        logic [1:0]             n_fixed;
        pcm_word_t              w0;
        pcm_word_t              w1;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lir_in_if  pcm_if ();
    lir_out_if res_if ();
    lir_cfg_if cfg_if ();

    linear_interp_resampler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pcm       (pcm_if),
        .resampled (res_if),
        .cfg       (cfg_if)
    );

    always #1 clk = ~clk;

    // predictor state
    int unsigned                src_hz;
    int unsigned                dst_hz;
    int unsigned                n_in;
    int unsigned                n_out;
    int unsigned                pos_idx;
    int unsigned                pos_frac;
    logic signed [SAMPLE_W-1:0] last_in;
    bit                         capped;
    logic signed [SAMPLE_W-1:0] pend[$];
    pcm_word_t                  step_out[$];

    pcm_word_t resampled_q[$];
    plan_row_t plan[$];

    int  fails       = 0;
    int  words_sent  = 0;
    int  words_seen  = 0;
    int  blocks_done = 0;
    int  cfg_writes  = 0;
    int  cycles      = 0;
    int  hold_left   = 0;
    int  stall_left  = 0;
    bit  quiet       = 1'b0;
    bit  burst_tog   = 1'b0;
    bit  burst_ack   = 1'b0;

    function automatic void clear_block();
        last_in  = '0;
        n_in     = 0;
        n_out    = 0;
        pos_idx  = 0;
        pos_frac = 0;
        capped   = 1'b0;
        pend.delete();
    endfunction

    function automatic bit out_due(int unsigned i, int unsigned n);
        return (longint'(i) + 1) * longint'(src_hz) <= longint'(n) * longint'(dst_hz);
    endfunction

    function automatic void emit(logic signed [SAMPLE_W-1:0] s, logic l);
        pcm_word_t w;
        w.sample = s;
        w.last   = l;
        if (step_out.size() < MAX_RESULTS)
        begin
            step_out.push_back(w);
        end
    endfunction

    function automatic void interp_next(logic signed [SAMPLE_W-1:0] a,
                                        logic signed [SAMPLE_W-1:0] b);
        longint      diff;
        longint      q;
        int unsigned f2;
        diff = longint'(b) - longint'(a);
        q    = (diff * longint'(pos_frac)) / longint'(dst_hz);
        f2   = pos_frac + src_hz;
        if (pend.size() < HOLD_DEPTH)
        begin
            pend.push_back(SAMPLE_W'(longint'(a) + q));
        end
        pos_idx  = pos_idx + f2 / dst_hz;
        pos_frac = f2 % dst_hz;
    endfunction

    // release while the block length is still open
    function automatic void release_open();
        while (pend.size() > 0 && !capped)
        begin
            if (n_out + 1 >= OUT_LIMIT)
            begin
                if (!out_due(n_out, n_in))
                begin
                    break;
                end
                emit(pend[0], 1'b1);
                n_out++;
                capped = 1'b1;
                pend.delete();
            end
            else if (out_due(n_out + 1, n_in))
            begin
                emit(pend.pop_front(), 1'b0);
                n_out++;
            end
            else
            begin
                break;
            end
        end
    endfunction

    function automatic void release_final();
        bit fin;
        while (pend.size() > 0 && !capped)
        begin
            if (!out_due(n_out, n_in))
            begin
                break;
            end
            fin = (n_out + 1 >= OUT_LIMIT) || !out_due(n_out + 1, n_in);
            emit(pend.pop_front(), fin);
            n_out++;
            if (fin)
            begin
                break;
            end
        end
    endfunction

    function automatic void resample_step(logic signed [SAMPLE_W-1:0] s, logic l);
        step_out.delete();
        if (n_in < MAX_BLOCK)
        begin
            if (n_in >= 1)
            begin
                while (!capped && pos_idx == n_in - 1 && pend.size() < HOLD_DEPTH)
                begin
                    interp_next(last_in, s);
                    n_in++;
                    release_open();
                    n_in--;
                end
            end
            last_in = s;
            n_in++;
        end
        if (!l)
        begin
            release_open();
            return;
        end
        // past the block end the right neighbour is zero
        if (n_in >= 1)
        begin
            while (!capped && pos_idx == n_in - 1 && pend.size() < HOLD_DEPTH)
            begin
                interp_next(last_in, SAMPLE_W'(0));
                release_open();
            end
        end
        release_final();
        clear_block();
    endfunction

    function automatic void rate_written(logic [CFG_INDEX_W-1:0] idx, logic [RATE_W-1:0] v);
        int unsigned r;
        r = v;
        if (r < RATE_LOW)
        begin
            r = RATE_LOW;
        end
        if (r > RATE_HIGH)
        begin
            r = RATE_HIGH;
        end
        if (idx == REG_SRC_RATE)
        begin
            src_hz = r;
            clear_block();
        end
        else if (idx == REG_DST_RATE)
        begin
            dst_hz = r;
            clear_block();
        end
    endfunction

    function automatic void book_step();
        foreach (step_out[i])
        begin
            resampled_q.push_back(step_out[i]);
        end
    endfunction

    function automatic void add_row(row_kind_t k, logic [CFG_INDEX_W-1:0] idx,
                                    logic [SAMPLE_W-1:0] v, logic l, logic fx, int n,
                                    logic signed [SAMPLE_W-1:0] s0, logic l0,
                                    logic signed [SAMPLE_W-1:0] s1, logic l1);
        plan_row_t r;
        r.kind      = k;
        r.index     = idx;
        r.value     = v;
        r.last      = l;
        r.fixed     = fx;
        r.n_fixed   = 2'(n);
        r.w0.sample = s0;
        r.w0.last   = l0;
        r.w1.sample = s1;
        r.w1.last   = l1;
        plan.push_back(r);
    endfunction

    function automatic void add_pcm(logic signed [SAMPLE_W-1:0] s, logic l);
        add_row(ROW_PCM, '0, s, l, 1'b0, 0, '0, 1'b0, '0, 1'b0);
    endfunction

    function automatic void add_fixed(logic signed [SAMPLE_W-1:0] s, logic l, int n,
                                      logic signed [SAMPLE_W-1:0] s0, logic l0,
                                      logic signed [SAMPLE_W-1:0] s1, logic l1);
        add_row(ROW_PCM, '0, s, l, 1'b1, n, s0, l0, s1, l1);
    endfunction

    function automatic void add_cfg(logic [CFG_INDEX_W-1:0] idx, logic [RATE_W-1:0] v);
        add_row(ROW_CFG, idx, v, 1'b0, 1'b0, 0, '0, 1'b0, '0, 1'b0);
    endfunction

    function automatic void fill_plan();
        // equal rates after reset: each word releases the one before it, a last word itself too
        add_fixed(16'sh7FFF, 1'b0, 0, 16'sh0000, 1'b0, 16'sh0000, 1'b0);
        add_fixed(16'sh8000, 1'b0, 1, 16'sh7FFF, 1'b0, 16'sh0000, 1'b0);
        add_fixed(16'sh0000, 1'b0, 1, 16'sh8000, 1'b0, 16'sh0000, 1'b0);
        add_fixed(16'shFFFF, 1'b1, 2, 16'sh0000, 1'b0, 16'shFFFF, 1'b1);
        add_fixed(16'sd12345, 1'b1, 1, 16'sd12345, 1'b1, 16'sh0000, 1'b0);
        // clamped writes, up by six
        add_cfg(REG_SRC_RATE, 16'd0);
        add_cfg(REG_DST_RATE, 16'hFFFF);
        add_pcm(16'sd6000, 1'b0);
        add_pcm(-16'sd6000, 1'b1);
        // unused register keeps the open block
        add_pcm(16'sd100, 1'b0);
        add_cfg(REG_SPARE, 16'd1234);
        add_pcm(16'sd200, 1'b1);
        add_cfg(REG_TOP, 16'd0);
        // down by six, five words give nothing
        add_cfg(REG_SRC_RATE, 16'd48000);
        add_cfg(REG_DST_RATE, 16'd7999);
        add_fixed(16'sh7FFF, 1'b0, 0, 16'sh0000, 1'b0, 16'sh0000, 1'b0);
        add_fixed(16'sh8000, 1'b0, 0, 16'sh0000, 1'b0, 16'sh0000, 1'b0);
        add_fixed(16'sh7FFF, 1'b0, 0, 16'sh0000, 1'b0, 16'sh0000, 1'b0);
        add_fixed(16'sh8000, 1'b0, 0, 16'sh0000, 1'b0, 16'sh0000, 1'b0);
        add_fixed(16'sd1, 1'b1, 0, 16'sh0000, 1'b0, 16'sh0000, 1'b0);
        // rate write drops the open block
        add_cfg(REG_DST_RATE, 16'd48001);
        add_fixed(16'sd7, 1'b0, 0, 16'sh0000, 1'b0, 16'sh0000, 1'b0);
        add_fixed(16'sd8, 1'b0, 1, 16'sd7, 1'b0, 16'sh0000, 1'b0);
        add_cfg(REG_SRC_RATE, 16'd24000);
        add_fixed(16'sd9, 1'b1, 2, 16'sd9, 1'b0, 16'sd5, 1'b1);
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 19))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return RATE_LOW;
            1:       return RATE_HIGH;
            2:       return RATE_W'($urandom);
            3:       return 16'd11025;
            4:       return 16'd22050;
            5:       return 16'd44100;
            default: return RATE_W'($urandom_range(8000, 48000));
        endcase
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    function automatic void check_word(logic signed [SAMPLE_W-1:0] s, logic l);
        pcm_word_t want;
        words_seen++;
        if (resampled_q.size() == 0)
        begin
            fails++;
            if (fails <= REPORT_MAX)
            begin
                $error("resampled word with nothing expected: out_sample %0d out_last %0b",
                       s, l);
            end
            return;
        end
        want = resampled_q.pop_front();
        if (s !== want.sample)
        begin
            fails++;
            if (fails <= REPORT_MAX)
            begin
                $error("out_sample: expected %0d, got %0d", want.sample, s);
            end
        end
        if (l !== want.last)
        begin
            fails++;
            if (fails <= REPORT_MAX)
            begin
                $error("out_last: expected %0b, got %0b", want.last, l);
            end
        end
    endfunction

    task automatic settle();
        pcm_if.valid <= 1'b0;
        while (resampled_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pcm_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pcm_if.valid     <= 1'b1;
        pcm_if.in_sample <= s;
        pcm_if.in_last   <= l;
        @(posedge clk);
        while (!pcm_if.ready)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (l)
        begin
            blocks_done++;
        end
        resample_step(s, l);
    endtask

    task automatic write_rate(input logic [CFG_INDEX_W-1:0] idx, input logic [RATE_W-1:0] v);
        settle();
        cfg_if.index <= idx;
        cfg_if.data  <= v;
        cfg_if.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
        rate_written(idx, v);
        cfg_writes++;
    endtask

    // output side: checker and ready pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                check_word(res_if.out_sample, res_if.out_last);
            end
            if (burst_tog != burst_ack)
            begin
                burst_ack = burst_tog;
                hold_left = BURST;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("** linear_interp_resampler: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int  k;
        int  b;
        int  n_blk;
        int  blk_len;
        int  phase;
        int  sent;
        bit  torn;

        rst_n            = 1'b0;
        pcm_if.valid     = 1'b0;
        pcm_if.in_sample = '0;
        pcm_if.in_last   = 1'b0;
        res_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        src_hz           = RATE_LOW;
        dst_hz           = RATE_LOW;
        clear_block();
        fill_plan();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                write_rate(plan[i].index, plan[i].value);
            end
            else
            begin
                send_word(plan[i].value, plan[i].last);
                if (!plan[i].fixed)
                begin
                    book_step();
                end
                else
                begin
                    if (plan[i].n_fixed > 0)
                    begin
                        resampled_q.push_back(plan[i].w0);
                    end
                    if (plan[i].n_fixed > 1)
                    begin
                        resampled_q.push_back(plan[i].w1);
                    end
                end
            end
        end

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_WORDS)
        begin
            quiet = (phase % 4 == 3);
            if (phase == 1)
            begin
                write_rate(REG_SRC_RATE, RATE_LOW);
                write_rate(REG_DST_RATE, RATE_HIGH);
                // long hold-off on the output while words keep coming
                burst_tog = ~burst_tog;
            end
            else
            begin
                write_rate(REG_SRC_RATE, pick_rate());
                write_rate(REG_DST_RATE, pick_rate());
                if ($urandom_range(0, 5) == 0)
                begin
                    write_rate(CFG_INDEX_W'($urandom_range(2, 255)), RATE_W'($urandom));
                end
            end
            n_blk = $urandom_range(2, 5);
            for (b = 0; b < n_blk; b++)
            begin
                blk_len = (phase == 1 && b == 0) ? 30 : pick_len();
                // an unfinished block gets dropped by the next rate write
                torn = (b == n_blk - 1) && ($urandom_range(0, 3) == 0);
                for (k = 0; k < blk_len; k++)
                begin
                    send_word(pick_sample(), (k == blk_len - 1) && !torn);
                    book_step();
                    sent++;
                end
            end
            phase++;
        end
        quiet = 1'b0;
        settle();

        $display("covered %0d pcm words in %0d closed blocks over %0d phases, %0d rate writes",
                 words_sent, blocks_done, phase, cfg_writes);
        $display("checked %0d resampled words, %0d mismatches", words_seen, fails);
        if (fails == 0)
        begin
            $display("** linear_interp_resampler: PASSED **");
        end
        else
        begin
            $display("** linear_interp_resampler: FAILED **");
        end
        $finish;
    end

endmodule
